// ===== hw/rtl/cia402_drive_enable_sequencer_defines.svh =====
// Assertion macros used by the bound checker file.
`ifndef CIA402_DRIVE_ENABLE_SEQUENCER_DEFINES_SVH
`define CIA402_DRIVE_ENABLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define CDES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CDES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cdes_pkg.sv =====
package cdes_pkg;

    // Stream widths, whole bytes
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 48;

    // Request fields, lowest bit first
    localparam int unsigned S_SW_LSB    = 0;
    localparam int unsigned S_OK_BIT    = 16;
    localparam int unsigned S_TDONE_BIT = 17;
    localparam int unsigned S_SON_BIT   = 18;
    localparam int unsigned S_SPEED_LSB = 19;
    localparam int unsigned S_USED_W    = 51;

    // Result fields, lowest bit first
    localparam int unsigned M_CW_LSB     = 0;
    localparam int unsigned M_MODE_LSB   = 8;
    localparam int unsigned M_SPEED_LSB  = 10;
    localparam int unsigned M_HEALTH_BIT = 42;
    localparam int unsigned M_PARAM_BIT  = 43;
    localparam int unsigned M_PHASE_LSB  = 44;
    localparam int unsigned M_USED_W     = 47;

    localparam logic [31:0] WAIT_TICKS_RESET = 32'd100;

    // Control words
    localparam logic [7:0] CW_DISABLE   = 8'd0;
    localparam logic [7:0] CW_SHUTDOWN  = 8'd6;
    localparam logic [7:0] CW_SWITCH_ON = 8'd7;
    localparam logic [7:0] CW_ENABLE_OP = 8'd15;

    // Modes of operation
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd3;

    // Status word bit patterns
    localparam logic [15:0] SW_DIS_MASK  = 16'h004F;
    localparam logic [15:0] SW_DIS_VALUE = 16'h0040;
    localparam logic [15:0] SW_MATCH_MASK = 16'h006F;
    localparam logic [15:0] SW_READY     = 16'h0021;
    localparam logic [15:0] SW_SWITCHED  = 16'h0023;
    localparam logic [15:0] SW_ENABLED   = 16'h0027;

    typedef enum logic [1:0] {
        PP_BUS_TIMING = 2'd0,
        PP_WAIT_OK    = 2'd1,
        PP_COUNTING   = 2'd2
    } t_param_phase;

    typedef enum logic [2:0] {
        DS_INIT       = 3'd0,
        DS_FIRST      = 3'd1,
        DS_SW_ON_DIS  = 3'd2,
        DS_READY      = 3'd3,
        DS_SWITCHED   = 3'd4,
        DS_ENABLED    = 3'd5
    } t_drive_step;

    function automatic logic sw_disabled(input logic [15:0] sw);
        return (sw & SW_DIS_MASK) == SW_DIS_VALUE;
    endfunction

    function automatic logic sw_is(input logic [15:0] sw, input logic [15:0] pattern);
        return (sw & SW_MATCH_MASK) == pattern;
    endfunction

endpackage

// ===== hw/rtl/cia402_drive_enable_sequencer.sv =====
// Channel      | Direction | Contents
// s_axis       | in        | one control cycle: status word, flags, speed setpoint
// m_axis       | out       | control word, mode, speed command, health, phase
// i_cfg        | in        | wait_ticks write, no read-back
//
// One request per cycle while m_axis is ready.
// Requests land in an input register; the sequencer state is updated from it and
// doubles as the result register.
// A stalled m_axis holds the result and the waiting request; s_axis is ready only
// while the input register is empty or moves on.
// Reset (i_rst_n, synchronous) clears all state and loads wait_ticks with 100.
module cia402_drive_enable_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // status_word[15:0], module_ok[16], timing_done[17], servo_on[18],
    // speed_request[50:19], zero fill [55:51]
    input  logic [cdes_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // control_word[7:0], operating_mode[9:8], speed_command[41:10],
    // servo_healthy[42], params_written[43], drive_phase[46:44], zero fill [47]
    output logic [cdes_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [31:0]                       i_cfg_wdata
);
    import cdes_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [15:0] r_status_word;
    logic        r_module_ok;
    logic        r_timing_done;
    logic        r_servo_on;
    logic [31:0] r_speed_request;

    // State and result register
    logic         r_out_valid;
    logic         r_healthy;
    logic [31:0]  r_wait_ticks;
    t_param_phase r_param_phase, n_param_phase;
    logic         r_param_done, n_param_done;
    logic [31:0]  r_wait_cnt, n_wait_cnt;
    t_drive_step  r_drive_step, n_drive_step;
    logic [7:0]   r_ctrl_hold, n_ctrl_hold;
    logic [1:0]   r_mode_hold, n_mode_hold;
    logic [31:0]  r_speed_hold, n_speed_hold;

    logic w_adv;
    logic w_sw_dis;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_sw_dis      = sw_disabled(r_status_word);

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_status_word   <= s_axis_tdata[S_SW_LSB +: 16];
            r_module_ok     <= s_axis_tdata[S_OK_BIT];
            r_timing_done   <= s_axis_tdata[S_TDONE_BIT];
            r_servo_on      <= s_axis_tdata[S_SON_BIT];
            r_speed_request <= s_axis_tdata[S_SPEED_LSB +: 32];
        end
    end

    // Parameter phase: bus timing, wait for module ok, count, then mark done
    always_comb begin
        n_param_phase = r_param_phase;
        n_param_done  = r_param_done;
        n_wait_cnt    = r_wait_cnt;
        case (r_param_phase)
            PP_BUS_TIMING: begin
                n_wait_cnt = '0;
                if (r_timing_done) begin
                    n_param_phase = PP_WAIT_OK;
                end
            end
            PP_COUNTING: begin
                if (r_wait_cnt >= r_wait_ticks) begin
                    n_param_done  = 1'b1;
                    n_param_phase = PP_WAIT_OK;
                    n_wait_cnt    = '0;
                end else if (r_wait_cnt != '1) begin
                    n_wait_cnt = r_wait_cnt + 32'd1;
                end
            end
            default: begin
                n_wait_cnt    = '0;
                n_param_phase = (r_module_ok && !r_param_done) ? PP_COUNTING : PP_WAIT_OK;
            end
        endcase
        // Drop the done mark when the module is lost
        if (!r_module_ok) begin
            n_param_done  = 1'b0;
            n_param_phase = PP_WAIT_OK;
            n_wait_cnt    = '0;
        end
    end

    // Power sequencer next step
    always_comb begin
        n_drive_step = r_drive_step;
        case (r_drive_step)
            DS_INIT: begin
                if (n_param_done) begin
                    n_drive_step = DS_FIRST;
                end
            end
            DS_FIRST: begin
                if (w_sw_dis) begin
                    n_drive_step = DS_SW_ON_DIS;
                end
            end
            DS_SW_ON_DIS: begin
                if (sw_is(r_status_word, SW_READY)) begin
                    n_drive_step = DS_READY;
                end
            end
            DS_READY: begin
                if (sw_is(r_status_word, SW_SWITCHED)) begin
                    n_drive_step = DS_SWITCHED;
                end
            end
            DS_SWITCHED: begin
                if (w_sw_dis) begin
                    n_drive_step = DS_SW_ON_DIS;
                end else if (sw_is(r_status_word, SW_ENABLED)) begin
                    n_drive_step = DS_ENABLED;
                end
            end
            DS_ENABLED: begin
                if (w_sw_dis) begin
                    n_drive_step = DS_SW_ON_DIS;
                end else if (!r_servo_on) begin
                    n_drive_step = DS_SWITCHED;
                end
            end
            default: begin
                n_drive_step = r_drive_step;
            end
        endcase
    end

    // Power sequencer outputs: control word, mode and speed holds
    always_comb begin
        n_ctrl_hold  = r_ctrl_hold;
        n_mode_hold  = r_mode_hold;
        n_speed_hold = r_speed_hold;
        case (r_drive_step)
            DS_INIT, DS_FIRST: begin
                n_ctrl_hold = CW_DISABLE;
            end
            DS_SW_ON_DIS: begin
                n_ctrl_hold = CW_SHUTDOWN;
            end
            DS_READY: begin
                n_ctrl_hold = CW_SWITCH_ON;
            end
            DS_SWITCHED: begin
                n_mode_hold = MODE_VELOCITY;
                if (r_servo_on) begin
                    n_ctrl_hold = CW_ENABLE_OP;
                end
                if (sw_is(r_status_word, SW_ENABLED)) begin
                    n_speed_hold = '0;
                end
            end
            DS_ENABLED: begin
                n_speed_hold = r_speed_request;
                if (!r_servo_on) begin
                    n_ctrl_hold = CW_SWITCH_ON;
                end
            end
            default: begin
                n_ctrl_hold = r_ctrl_hold;
            end
        endcase
    end

    // Advance state; the state registers double as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_healthy     <= 1'b0;
            r_param_phase <= PP_BUS_TIMING;
            r_param_done  <= 1'b0;
            r_wait_cnt    <= '0;
            r_drive_step  <= DS_INIT;
            r_ctrl_hold   <= CW_DISABLE;
            r_mode_hold   <= MODE_NONE;
            r_speed_hold  <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid   <= 1'b1;
                r_healthy     <= r_module_ok;
                r_param_phase <= n_param_phase;
                r_param_done  <= n_param_done;
                r_wait_cnt    <= n_wait_cnt;
                r_drive_step  <= n_drive_step;
                r_ctrl_hold   <= n_ctrl_hold;
                r_mode_hold   <= n_mode_hold;
                r_speed_hold  <= n_speed_hold;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_wait_ticks <= i_cfg_wdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {(M_TDATA_W - M_USED_W){1'b0}},
        r_drive_step,
        r_param_done,
        r_healthy,
        r_speed_hold,
        r_mode_hold,
        r_ctrl_hold
    };

endmodule

// ===== hw/rtl/cdes_checker.sv =====
`include "cia402_drive_enable_sequencer_defines.svh"

module cdes_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cdes_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cdes_pkg::*;

    logic       w_out_req;
    logic [7:0] w_cw;
    logic [1:0] w_mode;
    logic [2:0] w_phase;

    assign w_out_req = m_axis_tvalid && m_axis_tready;
    assign w_cw      = m_axis_tdata[M_CW_LSB +: 8];
    assign w_mode    = m_axis_tdata[M_MODE_LSB +: 2];
    assign w_phase   = m_axis_tdata[M_PHASE_LSB +: 3];

    // A stalled result holds
    `CDES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "m_axis result changed while stalled")

    // Only the four defined control words are ever sent
    `CDES_ASSERT_NOW(a_cw_legal, i_clk, i_rst_n, w_out_req,
        w_cw == CW_DISABLE || w_cw == CW_SHUTDOWN || w_cw == CW_SWITCH_ON || w_cw == CW_ENABLE_OP,
        "control word outside 0, 6, 7, 15")

    // Operation enabled implies velocity mode was already selected
    `CDES_ASSERT_NOW(a_enabled_mode, i_clk, i_rst_n, w_out_req && w_phase == DS_ENABLED,
        w_mode == MODE_VELOCITY, "operation enabled without velocity mode")

    // Parameters are only marked written while the module is healthy
    `CDES_ASSERT_NOW(a_done_healthy, i_clk, i_rst_n, w_out_req && m_axis_tdata[M_PARAM_BIT],
        m_axis_tdata[M_HEALTH_BIT], "params written reported with module not ok")

endmodule

bind cia402_drive_enable_sequencer cdes_checker u_cdes_checker (.*);

// ===== sim/cia402_drive_enable_sequencer_checker.sv =====
`timescale 1ns / 1ps

module cia402_drive_enable_sequencer_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // status_word[15:0], module_ok[16], timing_done[17], servo_on[18],
    // speed_request[50:19], zero fill [55:51]
    input  logic [cdes_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // control_word[7:0], operating_mode[9:8], speed_command[41:10],
    // servo_healthy[42], params_written[43], drive_phase[46:44], zero fill [47]
    input  logic [cdes_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [31:0]                       i_cfg_wdata,
    output int                                o_pending,
    output int                                o_fail_count
);

    import cdes_pkg::*;

    typedef struct packed {
        logic [15:0]        status_word;
        logic               module_ok;
        logic               timing_done;
        logic               servo_on;
        logic signed [31:0] speed_request;
    } t_cycle_request;

    typedef struct packed {
        logic [7:0]         control_word;
        logic [1:0]         operating_mode;
        logic signed [31:0] speed_command;
        logic               servo_healthy;
        logic               params_written;
        logic [2:0]         drive_phase;
    } t_drive_outputs;

    // Own copy of the register and the sequencer state
    logic [31:0]        wait_ticks_q;
    t_param_phase       param_phase_q;
    logic               params_done_q;
    logic [31:0]        wait_count_q;
    t_drive_step        step_q;
    logic [7:0]         cw_q;
    logic [1:0]         mode_q;
    logic signed [31:0] speed_q;

    t_drive_outputs drive_outputs_due[$];

    function automatic logic shows_disabled(input logic [15:0] sw);
        return (sw & SW_DIS_MASK) == SW_DIS_VALUE;
    endfunction

    function automatic logic shows_pattern(input logic [15:0] sw, input logic [15:0] pattern);
        return (sw & SW_MATCH_MASK) == pattern;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got_value,
                                   input logic [31:0] want_value);
        $display("[%0t] %s: got %0h, expected %0h", $time, field, got_value, want_value);
        o_fail_count++;
    endtask

    // Advance the parameter phase and the power sequencer by one control cycle
    task automatic advance_drive(input t_cycle_request rq, output t_drive_outputs res);
        logic start_enable;
        logic drop_enable;

        case (param_phase_q)
            PP_BUS_TIMING: begin
                wait_count_q = '0;
                if (rq.timing_done)
                    param_phase_q = PP_WAIT_OK;
            end
            PP_COUNTING: begin
                if (wait_count_q >= wait_ticks_q) begin
                    params_done_q = 1'b1;
                    param_phase_q = PP_WAIT_OK;
                    wait_count_q  = '0;
                end else if (wait_count_q != '1) begin
                    wait_count_q = wait_count_q + 32'd1;
                end
            end
            default: begin
                wait_count_q  = '0;
                param_phase_q = PP_WAIT_OK;
                if (rq.module_ok && !params_done_q)
                    param_phase_q = PP_COUNTING;
            end
        endcase

        // Module lost: drop the done mark from any phase
        if (!rq.module_ok) begin
            params_done_q = 1'b0;
            param_phase_q = PP_WAIT_OK;
            wait_count_q  = '0;
        end

        start_enable = (step_q == DS_SWITCHED) && rq.servo_on;
        drop_enable  = (step_q == DS_ENABLED) && !rq.servo_on;

        case (step_q)
            DS_INIT: begin
                cw_q = CW_DISABLE;
                if (params_done_q)
                    step_q = DS_FIRST;
            end
            DS_FIRST: begin
                cw_q = CW_DISABLE;
                if (shows_disabled(rq.status_word))
                    step_q = DS_SW_ON_DIS;
            end
            DS_SW_ON_DIS: begin
                cw_q = CW_SHUTDOWN;
                if (shows_pattern(rq.status_word, SW_READY))
                    step_q = DS_READY;
            end
            DS_READY: begin
                cw_q = CW_SWITCH_ON;
                if (shows_pattern(rq.status_word, SW_SWITCHED))
                    step_q = DS_SWITCHED;
            end
            DS_SWITCHED: begin
                mode_q = MODE_VELOCITY;
                if (start_enable)
                    cw_q = CW_ENABLE_OP;
                if (shows_pattern(rq.status_word, SW_ENABLED)) begin
                    speed_q = '0;
                    step_q  = DS_ENABLED;
                end
                // Fallback to switch-on-disabled wins over the step to operation enabled
                if (shows_disabled(rq.status_word))
                    step_q = DS_SW_ON_DIS;
            end
            DS_ENABLED: begin
                speed_q = rq.speed_request;
                if (drop_enable) begin
                    cw_q   = CW_SWITCH_ON;
                    step_q = DS_SWITCHED;
                end
                if (shows_disabled(rq.status_word))
                    step_q = DS_SW_ON_DIS;
            end
            default: ;
        endcase

        res.control_word   = cw_q;
        res.operating_mode = mode_q;
        res.speed_command  = speed_q;
        res.servo_healthy  = rq.module_ok;
        res.params_written = params_done_q;
        res.drive_phase    = step_q;
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_cycle_request rq;
        t_drive_outputs want;
        t_drive_outputs got;

        if (!i_rst_n) begin
            wait_ticks_q  = WAIT_TICKS_RESET;
            param_phase_q = PP_BUS_TIMING;
            params_done_q = 1'b0;
            wait_count_q  = '0;
            step_q        = DS_INIT;
            cw_q          = CW_DISABLE;
            mode_q        = MODE_NONE;
            speed_q       = '0;
            o_fail_count  = 0;
            drive_outputs_due.delete();
        end else begin
            if (i_cfg_we)
                wait_ticks_q = i_cfg_wdata;

            // Predict the result of each accepted request
            if (s_axis_tvalid && s_axis_tready) begin
                rq.status_word   = s_axis_tdata[S_SW_LSB +: 16];
                rq.module_ok     = s_axis_tdata[S_OK_BIT];
                rq.timing_done   = s_axis_tdata[S_TDONE_BIT];
                rq.servo_on      = s_axis_tdata[S_SON_BIT];
                rq.speed_request = s_axis_tdata[S_SPEED_LSB +: 32];
                advance_drive(rq, want);
                drive_outputs_due.push_back(want);
            end

            // Compare each accepted result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.control_word   = m_axis_tdata[M_CW_LSB +: 8];
                got.operating_mode = m_axis_tdata[M_MODE_LSB +: 2];
                got.speed_command  = m_axis_tdata[M_SPEED_LSB +: 32];
                got.servo_healthy  = m_axis_tdata[M_HEALTH_BIT];
                got.params_written = m_axis_tdata[M_PARAM_BIT];
                got.drive_phase    = m_axis_tdata[M_PHASE_LSB +: 3];
                if (drive_outputs_due.size() == 0) begin
                    report_mismatch("result with nothing pending, control_word",
                                    got.control_word, '0);
                end else begin
                    want = drive_outputs_due.pop_front();
                    if (got.control_word !== want.control_word)
                        report_mismatch("control_word", got.control_word, want.control_word);
                    if (got.operating_mode !== want.operating_mode)
                        report_mismatch("operating_mode", got.operating_mode,
                                        want.operating_mode);
                    if (got.speed_command !== want.speed_command)
                        report_mismatch("speed_command", got.speed_command,
                                        want.speed_command);
                    if (got.servo_healthy !== want.servo_healthy)
                        report_mismatch("servo_healthy", got.servo_healthy,
                                        want.servo_healthy);
                    if (got.params_written !== want.params_written)
                        report_mismatch("params_written", got.params_written,
                                        want.params_written);
                    if (got.drive_phase !== want.drive_phase)
                        report_mismatch("drive_phase", got.drive_phase, want.drive_phase);
                end
            end
        end
        o_pending <= drive_outputs_due.size();
    end

endmodule

// ===== sim/tb_cia402_drive_enable_sequencer.sv =====
`timescale 1ns / 1ps

module tb_cia402_drive_enable_sequencer;

    import cdes_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [31:0]          i_cfg_wdata = '0;

    int   pending_results;
    int   fail_count;
    int   cycle_count = 0;
    int   request_gap_pct = 30;
    int   result_stall_pct = 15;
    int   stall_left = 0;
    logic servo_on_level = 1'b0;

    cia402_drive_enable_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    cia402_drive_enable_sequencer_checker u_drive_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_pending     (pending_results),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result side in bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (result_stall_pct != 0 && $urandom_range(0, 99) < result_stall_pct) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one request, after an optional gap, and hold it until accepted
    task automatic send_request(input logic [15:0] sw, input logic ok, input logic tdone,
                                input logic son, input logic [31:0] speed);
        int gap;

        if (request_gap_pct != 0 && $urandom_range(0, 99) < request_gap_pct) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        // zero fill, speed_request, servo_on, timing_done, module_ok, status_word
        s_axis_tdata  <= {5'b0, speed, son, tdone, ok, sw};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Mostly well-formed status patterns with random don't-care bits
    task automatic send_random_request(input int drop_pm);
        logic [15:0] sw;
        logic [31:0] speed;
        int          pick;
        int          flip;

        pick = $urandom_range(0, 99);
        sw   = 16'($urandom_range(0, 65535));
        if (pick < 15) begin
            sw = (sw & ~SW_DIS_MASK) | SW_DIS_VALUE;
        end else if (pick < 35) begin
            sw = (sw & ~SW_MATCH_MASK) | SW_READY;
        end else if (pick < 55) begin
            sw = (sw & ~SW_MATCH_MASK) | SW_SWITCHED;
        end else if (pick < 80) begin
            sw = (sw & ~SW_MATCH_MASK) | SW_ENABLED;
        end else if (pick < 90) begin
            // near miss: one decoded bit off the enabled pattern
            flip = $urandom_range(0, 5);
            if (flip >= 4)
                flip = flip + 1;
            sw = ((sw & ~SW_MATCH_MASK) | SW_ENABLED) ^ (16'h0001 << flip);
        end

        pick = $urandom_range(0, 19);
        if (pick == 0)
            speed = 32'h7FFF_FFFF;
        else if (pick == 1)
            speed = 32'h8000_0000;
        else
            speed = $urandom;

        if ($urandom_range(0, 99) < 20)
            servo_on_level = ~servo_on_level;

        send_request(sw, $urandom_range(0, 999) >= drop_pm, $urandom_range(0, 9) != 0,
                     servo_on_level, speed);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_wait_ticks(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Parameter phase corners: timing pending, timing done, module lost early
        send_request(16'hFFFF, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF);
        send_request(16'h0000, 1'b1, 1'b1, 1'b0, 32'h8000_0000);
        send_request(16'h0040, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_request(16'h0021, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        send_request(16'h0027, 1'b0, 1'b1, 1'b1, 32'h0000_0001);

        // Count out the reset value of wait_ticks
        repeat (130) send_random_request(2);

        // Walk the power sequencer with a zero wait
        wait_drained();
        write_wait_ticks(32'd0);
        send_request(16'h0000, 1'b1, 1'b1, 1'b0, 32'h0000_0011);
        send_request(16'h0000, 1'b1, 1'b1, 1'b0, 32'h0000_0022);
        send_request(16'h0040, 1'b1, 1'b1, 1'b0, 32'h0000_0033);
        send_request(16'h0040, 1'b1, 1'b1, 1'b0, 32'h0000_0044);
        send_request(16'h0021, 1'b1, 1'b1, 1'b0, 32'h0000_0055);
        send_request(16'h0023, 1'b1, 1'b1, 1'b0, 32'h0000_0066);
        send_request(16'h0021, 1'b1, 1'b1, 1'b1, 32'h0000_0077);
        send_request(16'h0027, 1'b1, 1'b1, 1'b1, 32'h0000_0088);
        send_request(16'hFFA7, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF);
        send_request(16'h0027, 1'b1, 1'b1, 1'b1, 32'h8000_0000);
        send_request(16'h0027, 1'b1, 1'b1, 1'b0, 32'hDEAD_BEEF);
        // enable request and fallback in the same cycle
        send_request(16'h0040, 1'b1, 1'b1, 1'b1, 32'h0000_0099);
        send_request(16'h0021, 1'b1, 1'b1, 1'b1, 32'h0000_00AA);
        send_request(16'h0023, 1'b1, 1'b1, 1'b1, 32'h0000_00BB);
        send_request(16'h0027, 1'b1, 1'b1, 1'b1, 32'h0000_00CC);
        // disable request and fallback in the same cycle
        send_request(16'h0040, 1'b1, 1'b1, 1'b0, 32'h1234_5678);
        send_request(16'h0061, 1'b1, 1'b1, 1'b0, 32'h0000_00DD);
        send_request(16'h0000, 1'b0, 1'b1, 1'b0, 32'h0000_00EE);
        send_request(16'h0000, 1'b1, 1'b1, 1'b0, 32'h0000_00FF);
        send_request(16'h0000, 1'b1, 1'b0, 1'b0, 32'h0000_0100);

        // Random phases at several wait settings, one stretch without idling
        wait_drained();
        write_wait_ticks(32'd1);
        request_gap_pct  = 0;
        result_stall_pct = 0;
        repeat (60) send_random_request(30);

        wait_drained();
        write_wait_ticks(32'hFFFF_FFFF);
        request_gap_pct  = 40;
        result_stall_pct = 40;
        repeat (40) send_random_request(20);

        wait_drained();
        write_wait_ticks(32'd5);
        request_gap_pct  = 30;
        result_stall_pct = 15;
        repeat (70) send_random_request(20);

        wait_drained();
        write_wait_ticks(32'd0);
        request_gap_pct  = 10;
        result_stall_pct = 30;
        repeat (60) send_random_request(60);

        // Closing phase at full rate
        wait_drained();
        write_wait_ticks(32'd12);
        request_gap_pct  = 0;
        result_stall_pct = 0;
        repeat (60) send_random_request(10);

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cdes_pkg.sv
hw/rtl/cia402_drive_enable_sequencer.sv
hw/rtl/cdes_checker.sv
sim/cia402_drive_enable_sequencer_checker.sv
sim/tb_cia402_drive_enable_sequencer.sv
